@@ rtl/core/rhc_pkg.sv @@
// Shared constants and types for the RGB to HSV converter.
package rhc_pkg;

    localparam int COMPONENT_BITS_DEF = 16;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } t_max_sel;

endpackage

@@ rtl/core/rgb_to_hsv_convert.sv @@
// RGB to HSV pixel converter: compare, difference and numerator stages, then one
// restoring division step per stage for hue and saturation.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+----------------------------------
//  input   | i_valid  | o_stall  | i_red, i_green, i_blue
//  output  | o_valid  | i_stall  | o_hue, o_saturation, o_value
//
// One item per cycle while no stall holds the pipeline.
// The two quotients take one bit per stage, COMPONENT_BITS stages in all.
// Reset clears the valid bit of every stage; payload registers are not reset.
// A stage holds only while it is full and the stage after it holds, so
// bubbles close up under a stall and an item enters whenever the first stage frees.
module rgb_to_hsv_convert
    import rhc_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [COMPONENT_BITS-1:0] i_red,
    input  logic [COMPONENT_BITS-1:0] i_green,
    input  logic [COMPONENT_BITS-1:0] i_blue,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [COMPONENT_BITS-1:0] o_hue,
    output logic [COMPONENT_BITS-1:0] o_saturation,
    output logic [COMPONENT_BITS-1:0] o_value
);

    localparam int W   = COMPONENT_BITS;
    localparam int NST = W + 3;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST:0]   w_rdy;

    assign w_rdy[NST] = !i_stall;

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_ctl
            assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
            if (k == 0) begin : g_first
                assign n_vld[k] = w_rdy[k] ? i_valid : r_vld[k];
            end else begin : g_rest
                assign n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NST-1];

    // stage 1: largest and smallest component
    logic [W-1:0] r_s1_r, r_s1_g, r_s1_b, r_s1_mx, r_s1_mn;
    t_max_sel     r_s1_sel;
    logic [W-1:0] n_s1_mx, n_s1_mn;
    t_max_sel     n_s1_sel;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_s1_sel = MAX_RED;
            n_s1_mx  = i_red;
        end else if (i_green >= i_blue) begin
            n_s1_sel = MAX_GREEN;
            n_s1_mx  = i_green;
        end else begin
            n_s1_sel = MAX_BLUE;
            n_s1_mx  = i_blue;
        end
        n_s1_mn = i_red;
        if (i_green < n_s1_mn) n_s1_mn = i_green;
        if (i_blue < n_s1_mn) n_s1_mn = i_blue;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_r   <= i_red;
            r_s1_g   <= i_green;
            r_s1_b   <= i_blue;
            r_s1_mx  <= n_s1_mx;
            r_s1_mn  <= n_s1_mn;
            r_s1_sel <= n_s1_sel;
        end
    end

    // stage 2: delta and signed component difference
    logic [W-1:0] r_s2_delta, r_s2_mx;
    logic [W:0]   r_s2_diff;
    t_max_sel     r_s2_sel;
    logic [W:0]   n_s2_diff;

    always_comb begin
        case (r_s1_sel)
            MAX_RED:   n_s2_diff = {1'b0, r_s1_g} - {1'b0, r_s1_b};
            MAX_GREEN: n_s2_diff = {1'b0, r_s1_b} - {1'b0, r_s1_r};
            MAX_BLUE:  n_s2_diff = {1'b0, r_s1_r} - {1'b0, r_s1_g};
            default:   n_s2_diff = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s2_delta <= r_s1_mx - r_s1_mn;
            r_s2_mx    <= r_s1_mx;
            r_s2_diff  <= n_s2_diff;
            r_s2_sel   <= r_s1_sel;
        end
    end

    // stage 3 and division stages share these arrays; entry 0 is stage 3
    logic [W+2:0] r_den  [0:W];
    logic [W+2:0] r_hrem [0:W];
    logic [W-1:0] r_hq   [0:W];
    logic [W-1:0] r_srem [0:W];
    logic [W-1:0] r_slo  [0:W];
    logic [W-1:0] r_sq   [0:W];
    logic [W-1:0] r_mx   [0:W];
    logic         r_grey [0:W];

    logic [W+3:0] n_den, n_base, n_diff, n_num;

    always_comb begin
        n_den  = {2'b00, r_s2_delta, 2'b00} + {3'b000, r_s2_delta, 1'b0};
        n_diff = {{3{r_s2_diff[W]}}, r_s2_diff};
        case (r_s2_sel)
            MAX_RED:   n_base = '0;
            MAX_GREEN: n_base = {3'b000, r_s2_delta, 1'b0};
            MAX_BLUE:  n_base = {2'b00, r_s2_delta, 2'b00};
            default:   n_base = '0;
        endcase
        if (r_s2_sel == MAX_RED && r_s2_diff[W]) begin
            n_num = n_den + n_diff;
        end else begin
            n_num = n_base + n_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_den[0]  <= n_den[W+2:0];
            r_hrem[0] <= n_num[W+2:0];
            r_hq[0]   <= '0;
            r_srem[0] <= r_s2_delta - {{(W-1){1'b0}}, 1'b1};
            r_slo[0]  <= '0 - r_s2_delta;
            r_sq[0]   <= '0;
            r_mx[0]   <= r_s2_mx;
            r_grey[0] <= (r_s2_delta == '0);
        end
    end

    genvar j;
    generate
        for (j = 0; j < W; j++) begin : g_div
            logic [W+3:0] w_ht;
            logic [W+3:0] w_hsub;
            logic         w_hbit;
            logic [W:0]   w_st;
            logic [W:0]   w_ssub;
            logic         w_sbit;

            always_comb begin
                w_ht   = {r_hrem[j], 1'b0};
                w_hsub = w_ht - {1'b0, r_den[j]};
                w_hbit = (w_ht >= {1'b0, r_den[j]});
                w_st   = {r_srem[j], r_slo[j][W-1]};
                w_ssub = w_st - {1'b0, r_mx[j]};
                w_sbit = (w_st >= {1'b0, r_mx[j]});
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[j+3]) begin
                    r_den[j+1]  <= r_den[j];
                    r_hrem[j+1] <= w_hbit ? w_hsub[W+2:0] : w_ht[W+2:0];
                    r_hq[j+1]   <= r_grey[j] ? '0 : {r_hq[j][W-2:0], w_hbit};
                    r_srem[j+1] <= w_sbit ? w_ssub[W-1:0] : w_st[W-1:0];
                    r_slo[j+1]  <= {r_slo[j][W-2:0], 1'b0};
                    r_sq[j+1]   <= r_grey[j] ? '0 : {r_sq[j][W-2:0], w_sbit};
                    r_mx[j+1]   <= r_mx[j];
                    r_grey[j+1] <= r_grey[j];
                end
            end
        end
    endgenerate

    assign o_hue        = r_hq[W];
    assign o_saturation = r_sq[W];
    assign o_value      = r_mx[W];

endmodule

@@ tb/tb_rgb_to_hsv_convert.sv @@
`timescale 1ns / 100ps
// Testbench for rgb_to_hsv_convert: queued pixel driver, HSV checker, random and long stalls.
module tb_rgb_to_hsv_convert
    import rhc_pkg::*;
();

    localparam int W            = COMPONENT_BITS_DEF;
    localparam int N_RANDOM     = 1800;
    localparam int QUIET_TAIL   = 300;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [W-1:0] FULL = {W{1'b1}};

    typedef struct packed {
        logic [W-1:0] red;
        logic [W-1:0] green;
        logic [W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [W-1:0] hue;
        logic [W-1:0] saturation;
        logic [W-1:0] value;
    } t_hsv;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         i_stall = 1'b0;
    logic [W-1:0] i_red   = '0;
    logic [W-1:0] i_green = '0;
    logic [W-1:0] i_blue  = '0;
    logic         o_stall;
    logic         o_valid;
    logic [W-1:0] o_hue;
    logic [W-1:0] o_saturation;
    logic [W-1:0] o_value;

    t_rgb        pixel_feed[$];
    t_hsv        hsv_due[$];
    int          n_errors  = 0;
    int          n_checked = 0;
    int          send_gap  = 0;
    int          recv_gap  = 0;
    int          hold_cnt  = 0;
    bit          hold_done = 1'b0;
    int unsigned cycles    = 0;

    rgb_to_hsv_convert DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_value      (o_value)
    );

    function automatic t_hsv hsv_of(t_rgb px);
        logic [W-1:0]   mx;
        logic [W-1:0]   mn;
        logic [W-1:0]   delta;
        logic [W+2:0]   den;
        logic [W+2:0]   pos;
        logic [W+2:0]   neg;
        logic [W+2:0]   num;
        logic [2*W+2:0] quo;
        logic [2*W-1:0] sat_q;
        t_max_sel       sel;
        t_hsv           res;
        mx  = px.red;
        sel = MAX_RED;
        if (px.green > mx) begin
            mx  = px.green;
            sel = MAX_GREEN;
        end
        if (px.blue > mx) begin
            mx  = px.blue;
            sel = MAX_BLUE;
        end
        mn = px.red;
        if (px.green < mn) mn = px.green;
        if (px.blue < mn) mn = px.blue;
        delta = mx - mn;
        if (delta == 0) begin
            res.hue        = '0;
            res.saturation = '0;
            res.value      = mn;
            return res;
        end
        den = 6 * delta;
        case (sel)
            MAX_RED: begin
                pos = px.green;
                neg = px.blue;
            end
            MAX_GREEN: begin
                pos = 2 * delta + px.blue;
                neg = px.red;
            end
            default: begin
                pos = 4 * delta + px.red;
                neg = px.green;
            end
        endcase
        // wrap a negative numerator by one full turn
        num = (pos >= neg) ? pos - neg : den - (neg - pos);
        if (num >= den) num = num - den;
        quo   = {num, {W{1'b0}}} / den;
        sat_q = delta * FULL / mx;
        res.hue        = quo[W-1:0];
        res.saturation = sat_q[W-1:0];
        res.value      = mx;
        return res;
    endfunction

    function automatic t_rgb random_pixel();
        t_rgb px;
        int   span;
        px.red   = W'($urandom);
        px.green = W'($urandom);
        px.blue  = W'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: px.green = px.red;
                    1: px.blue = px.red;
                    default: px.blue = px.green;
                endcase
            end
            2: begin
                span     = $urandom_range(1, 3);
                px.red   = W'($urandom_range(3, int'(FULL) - 3));
                px.green = px.red + W'($urandom_range(0, span)) - W'(span / 2);
                px.blue  = px.red + W'($urandom_range(0, span)) - W'(span / 2);
            end
            3: begin
                if ($urandom_range(0, 1) == 0) px.red = $urandom_range(0, 1) ? FULL : '0;
                if ($urandom_range(0, 1) == 0) px.green = $urandom_range(0, 1) ? FULL : '0;
                if ($urandom_range(0, 1) == 0) px.blue = $urandom_range(0, 1) ? FULL : '0;
            end
            default: ;
        endcase
        return px;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_rgb_to_hsv_convert NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin : driver
        t_rgb px;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) hsv_due.push_back(hsv_of({i_red, i_green, i_blue}));
            if (i_valid && o_stall) begin
                // hold the stalled item
            end else if (send_gap != 0) begin
                i_valid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (pixel_feed.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                i_valid <= 1'b0;
                send_gap = $urandom_range(0, 18);
            end else if (pixel_feed.size() != 0) begin
                px = pixel_feed.pop_front();
                i_valid <= 1'b1;
                i_red   <= px.red;
                i_green <= px.green;
                i_blue  <= px.blue;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && n_checked >= HOLD_AT) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_hsv want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (hsv_due.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected item hue %h saturation %h value %h",
                             $time, o_hue, o_saturation, o_value);
                end else begin
                    want = hsv_due.pop_front();
                    n_checked++;
                    if (o_hue !== want.hue) begin
                        n_errors++;
                        $display("%0t: hue expected %h actual %h", $time, want.hue, o_hue);
                    end
                    if (o_saturation !== want.saturation) begin
                        n_errors++;
                        $display("%0t: saturation expected %h actual %h",
                                 $time, want.saturation, o_saturation);
                    end
                    if (o_value !== want.value) begin
                        n_errors++;
                        $display("%0t: value expected %h actual %h", $time, want.value, o_value);
                    end
                end
            end
            if (hold_cnt != 0) begin
                i_stall <= 1'b1;
            end else if (recv_gap != 0) begin
                i_stall <= 1'b1;
                recv_gap = recv_gap - 1;
            end else if (pixel_feed.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                recv_gap = $urandom_range(0, 18);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        pixel_feed.push_back({16'h0000, 16'h0000, 16'h0000});
        pixel_feed.push_back({16'hffff, 16'hffff, 16'hffff});
        pixel_feed.push_back({16'h0064, 16'h0064, 16'h0064});
        pixel_feed.push_back({16'hffff, 16'h0000, 16'h0000});
        pixel_feed.push_back({16'h0000, 16'hffff, 16'h0000});
        pixel_feed.push_back({16'h0000, 16'h0000, 16'hffff});
        pixel_feed.push_back({16'hffff, 16'hffff, 16'h0000});
        pixel_feed.push_back({16'hffff, 16'h0000, 16'hffff});
        pixel_feed.push_back({16'h0000, 16'hffff, 16'hffff});
        pixel_feed.push_back({16'h1234, 16'h1234, 16'h0100});
        pixel_feed.push_back({16'h03e8, 16'h00c8, 16'h01f4});
        pixel_feed.push_back({16'hffff, 16'h0000, 16'h0001});
        pixel_feed.push_back({16'hffff, 16'h0001, 16'h0000});
        pixel_feed.push_back({16'h0001, 16'h0000, 16'h0000});
        pixel_feed.push_back({16'h0000, 16'h0001, 16'h0000});
        pixel_feed.push_back({16'h0000, 16'h0000, 16'h0001});
        pixel_feed.push_back({16'h8000, 16'h7fff, 16'h7fff});
        pixel_feed.push_back({16'h5555, 16'haaaa, 16'hffff});
        pixel_feed.push_back({16'hffff, 16'haaaa, 16'h5555});
        pixel_feed.push_back({16'h0123, 16'hfedc, 16'h8000});
        pixel_feed.push_back({16'hfffe, 16'hffff, 16'hfffe});
        pixel_feed.push_back({16'h7fff, 16'h8000, 16'hffff});
        pixel_feed.push_back({16'hffff, 16'hfffe, 16'hffff});
        for (int k = 0; k < N_RANDOM; k++) pixel_feed.push_back(random_pixel());

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pixel_feed.size() != 0 || i_valid) @(posedge i_clk);
        while (hsv_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_rgb_to_hsv_convert OK");
        end else begin
            $display("tb_rgb_to_hsv_convert NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rhc_pkg.sv
rtl/core/rgb_to_hsv_convert.sv
tb/tb_rgb_to_hsv_convert.sv
